### rtl/awbd_pkg.sv
`timescale 1ns / 1ps
package awbd_pkg;

    localparam int CFG_W       = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int DEF_MAX_DIM = 512;
    localparam int PIX_W       = 32;
    localparam int XY_W        = 9;
    localparam int CH_W        = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

    typedef struct packed {
        logic start;
        logic abort;
    } div_ctl_t;

endpackage

### rtl/awbd_ram.sv
`timescale 1ns / 1ps
module awbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/awbd_div.sv
`timescale 1ns / 1ps
module awbd_div
    import awbd_pkg::*;
#(
    parameter int DVD_W = 35,
    parameter int DVS_W = 27
) (
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctl_t         ctl,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.abort)
            begin
                busy_reg <= 1'b0;
            end
            else if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### rtl/alpha_weighted_box_downscale.sv
`timescale 1ns / 1ps
// Beats are taken one at a time: after its accept, a beat that finishes no box passes through READ,
// STEP, BNDC and BNDR before the next beat is taken, plus one divider pass per box edge crossed.
// A beat that finishes a box adds up to four divider passes and an EMIT state that loads the output
// once the output register is free (no divider passes when the box alpha is zero).
// Each divider pass holds its state until the divider is done.
// After reset and after every register write, all MAX_DIM sums are cleared and two divider passes run.
module alpha_weighted_box_downscale
    import awbd_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PIX_W-1:0]     pixel,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     out_pixel,
    output logic [XY_W-1:0]      dst_x,
    output logic [XY_W-1:0]      dst_y,
    output logic                 last
);

    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int CNT_W   = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int ALPHA_W = CNT_W + CH_W;
    localparam int COL_W   = CNT_W + 2 * CH_W;
    localparam int MEM_W   = 3 * COL_W + ALPHA_W + CNT_W;
    localparam int PROD_W  = 2 * DIM_W;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_READ  = 11'b00000000100,
        S_DIVA  = 11'b00000001000,
        S_DIVR  = 11'b00000010000,
        S_DIVG  = 11'b00000100000,
        S_DIVB  = 11'b00001000000,
        S_EMIT  = 11'b00010000000,
        S_STEP  = 11'b00100000000,
        S_BNDC  = 11'b01000000000,
        S_BNDR  = 11'b10000000000
    } state_t;

    state_t state_reg;

    logic [CFG_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [DIM_W-1:0] sw, sh, dw, dh;
    logic [31:0]      sw32, sh32, dw32, dh32;

    logic [IDX_W-1:0] src_col_reg, src_row_reg, dst_col_reg, dst_row_reg, clr_reg;
    logic [DIM_W-1:0] col_end_reg, row_end_reg;
    logic             need_c_reg, need_r_reg, div_run_reg;

    logic [PIX_W-1:0]   pix_reg;
    logic [COL_W-1:0]   red_reg, green_reg, blue_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CH_W-1:0]    a_reg, r_reg, g_reg, b_reg;

    logic                 out_valid_reg, last_reg;
    logic [PIX_W-1:0]     out_pixel_reg;
    logic [XY_W-1:0]      dst_x_reg, dst_y_reg;

    logic [MEM_W-1:0]   rdata, wdata;
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   waddr;
    logic [COL_W-1:0]   red_next, green_next, blue_next;
    logic [ALPHA_W-1:0] alpha_next;
    logic [CNT_W-1:0]   cnt_next;
    logic [CH_W-1:0]    al;
    logic               emit, col_last, row_last, in_fire, out_free, cfg_hit;
    logic [DIM_W-1:0]   src_col_inc, src_row_inc, dst_col_inc, dst_row_inc;

    div_ctl_t           div_ctl;
    logic [COL_W-1:0]   div_dvd, div_q;
    logic [ALPHA_W-1:0] div_dvs;
    logic               div_done, div_state, div_ok;
    logic [PROD_W-1:0]  bnd_prod;

    always_comb
    begin
        sw32 = (src_w_reg == '0) ? 32'd1 :
               ((32'(src_w_reg) > 32'(MAX_DIM)) ? 32'(MAX_DIM) : 32'(src_w_reg));
        sh32 = (src_h_reg == '0) ? 32'd1 :
               ((32'(src_h_reg) > 32'(MAX_DIM)) ? 32'(MAX_DIM) : 32'(src_h_reg));
        dw32 = (dst_w_reg == '0) ? 32'd1 :
               ((32'(dst_w_reg) > sw32) ? sw32 : 32'(dst_w_reg));
        dh32 = (dst_h_reg == '0) ? 32'd1 :
               ((32'(dst_h_reg) > sh32) ? sh32 : 32'(dst_h_reg));
        sw = sw32[DIM_W-1:0];
        sh = sh32[DIM_W-1:0];
        dw = dw32[DIM_W-1:0];
        dh = dh32[DIM_W-1:0];
    end

    always_comb
    begin
        src_col_inc = DIM_W'(src_col_reg) + 1'b1;
        src_row_inc = DIM_W'(src_row_reg) + 1'b1;
        dst_col_inc = DIM_W'(dst_col_reg) + 1'b1;
        dst_row_inc = DIM_W'(dst_row_reg) + 1'b1;
        col_last    = (src_col_inc >= sw);
        row_last    = (src_row_inc >= sh);
        emit        = (src_col_inc >= col_end_reg) && (src_row_inc >= row_end_reg);

        al         = pix_reg[31:24];
        red_next   = rdata[MEM_W-1 -: COL_W]
                     + COL_W'(2 * CH_W'(0) + pix_reg[23:16] * al);
        green_next = rdata[MEM_W-COL_W-1 -: COL_W]
                     + COL_W'(2 * CH_W'(0) + pix_reg[15:8] * al);
        blue_next  = rdata[MEM_W-2*COL_W-1 -: COL_W]
                     + COL_W'(2 * CH_W'(0) + pix_reg[7:0] * al);
        alpha_next = rdata[CNT_W +: ALPHA_W] + ALPHA_W'(al);
        cnt_next   = rdata[CNT_W-1:0] + 1'b1;
    end

    assign cfg_hit  = cfg_we && (cfg_index == REG_SRC_WIDTH || cfg_index == REG_SRC_HEIGHT ||
                                 cfg_index == REG_DST_WIDTH || cfg_index == REG_DST_HEIGHT);
    assign in_ready = (state_reg == S_IDLE) && !cfg_hit;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        ram_re = in_fire;
        ram_we = (state_reg == S_CLEAR) || (state_reg == S_READ);
        waddr  = (state_reg == S_CLEAR) ? clr_reg : dst_col_reg;
        if ((state_reg == S_CLEAR) || emit)
        begin
            wdata = '0;
        end
        else
        begin
            wdata = {red_next, green_next, blue_next, alpha_next, cnt_next};
        end
    end

    awbd_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_DIM)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ram_re),
        .raddr (dst_col_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        div_state = (state_reg == S_DIVA) || (state_reg == S_DIVR) ||
                    (state_reg == S_DIVG) || (state_reg == S_DIVB) ||
                    ((state_reg == S_BNDC) && need_c_reg) ||
                    ((state_reg == S_BNDR) && need_r_reg);
        div_ctl.start = div_state && !div_run_reg && !cfg_hit;
        div_ctl.abort = cfg_hit;
        div_ok        = div_run_reg && div_done;
        if (state_reg == S_BNDC)
        begin
            bnd_prod = PROD_W'(dst_col_inc) * PROD_W'(sw);
        end
        else
        begin
            bnd_prod = PROD_W'(dst_row_inc) * PROD_W'(sh);
        end
        unique case (state_reg)
            S_DIVA:
            begin
                div_dvd = COL_W'(alpha_reg);
                div_dvs = ALPHA_W'(cnt_reg);
            end
            S_DIVR:
            begin
                div_dvd = red_reg;
                div_dvs = alpha_reg;
            end
            S_DIVG:
            begin
                div_dvd = green_reg;
                div_dvs = alpha_reg;
            end
            S_DIVB:
            begin
                div_dvd = blue_reg;
                div_dvs = alpha_reg;
            end
            S_BNDC:
            begin
                div_dvd = COL_W'(bnd_prod);
                div_dvs = ALPHA_W'(dw);
            end
            default:
            begin
                div_dvd = COL_W'(bnd_prod);
                div_dvs = ALPHA_W'(dh);
            end
        endcase
    end

    awbd_div #(
        .DVD_W (COL_W),
        .DVS_W (ALPHA_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            src_w_reg     <= CFG_W'(1);
            src_h_reg     <= CFG_W'(1);
            dst_w_reg     <= CFG_W'(1);
            dst_h_reg     <= CFG_W'(1);
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            dst_col_reg   <= '0;
            dst_row_reg   <= '0;
            clr_reg       <= '0;
            col_end_reg   <= DIM_W'(1);
            row_end_reg   <= DIM_W'(1);
            need_c_reg    <= 1'b1;
            need_r_reg    <= 1'b1;
            div_run_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (div_ctl.start)
            begin
                div_run_reg <= 1'b1;
            end
            else if (div_done)
            begin
                div_run_reg <= 1'b0;
            end

            if (cfg_hit)
            begin
                unique case (cfg_index)
                    REG_SRC_WIDTH:  src_w_reg <= cfg_data;
                    REG_SRC_HEIGHT: src_h_reg <= cfg_data;
                    REG_DST_WIDTH:  dst_w_reg <= cfg_data;
                    REG_DST_HEIGHT: dst_h_reg <= cfg_data;
                    default:        ;
                endcase
                state_reg   <= S_CLEAR;
                clr_reg     <= '0;
                src_col_reg <= '0;
                src_row_reg <= '0;
                dst_col_reg <= '0;
                dst_row_reg <= '0;
                div_run_reg <= 1'b0;
            end
            else
            begin
                unique case (state_reg)
                    S_CLEAR:
                    begin
                        clr_reg <= clr_reg + 1'b1;
                        if (clr_reg == IDX_W'(MAX_DIM - 1))
                        begin
                            need_c_reg <= 1'b1;
                            need_r_reg <= 1'b1;
                            state_reg  <= S_BNDC;
                        end
                    end
                    S_IDLE:
                    begin
                        if (in_fire)
                        begin
                            state_reg <= S_READ;
                        end
                    end
                    S_READ:
                    begin
                        if (!emit)
                        begin
                            state_reg <= S_STEP;
                        end
                        else if (alpha_next == '0)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_DIVA;
                        end
                    end
                    S_DIVA:
                    begin
                        if (div_ok)
                        begin
                            state_reg <= S_DIVR;
                        end
                    end
                    S_DIVR:
                    begin
                        if (div_ok)
                        begin
                            state_reg <= S_DIVG;
                        end
                    end
                    S_DIVG:
                    begin
                        if (div_ok)
                        begin
                            state_reg <= S_DIVB;
                        end
                    end
                    S_DIVB:
                    begin
                        if (div_ok)
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                    S_EMIT:
                    begin
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_STEP;
                        end
                    end
                    S_STEP:
                    begin
                        state_reg <= S_BNDC;
                        if (col_last)
                        begin
                            src_col_reg <= '0;
                            dst_col_reg <= '0;
                            need_c_reg  <= 1'b1;
                            if (row_last)
                            begin
                                src_row_reg <= '0;
                                dst_row_reg <= '0;
                                need_r_reg  <= 1'b1;
                            end
                            else
                            begin
                                src_row_reg <= src_row_reg + 1'b1;
                                if (src_row_inc >= row_end_reg)
                                begin
                                    dst_row_reg <= dst_row_reg + 1'b1;
                                    need_r_reg  <= 1'b1;
                                end
                                else
                                begin
                                    need_r_reg <= 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            src_col_reg <= src_col_reg + 1'b1;
                            need_r_reg  <= 1'b0;
                            if (src_col_inc >= col_end_reg)
                            begin
                                dst_col_reg <= dst_col_reg + 1'b1;
                                need_c_reg  <= 1'b1;
                            end
                            else
                            begin
                                need_c_reg <= 1'b0;
                            end
                        end
                    end
                    S_BNDC:
                    begin
                        if (!need_c_reg)
                        begin
                            state_reg <= S_BNDR;
                        end
                        else if (div_ok)
                        begin
                            col_end_reg <= div_q[DIM_W-1:0];
                            state_reg   <= S_BNDR;
                        end
                    end
                    S_BNDR:
                    begin
                        if (!need_r_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (div_ok)
                        begin
                            row_end_reg <= div_q[DIM_W-1:0];
                            state_reg   <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_CLEAR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pix_reg <= pixel;
        end
        if (state_reg == S_READ)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= alpha_next;
            cnt_reg   <= cnt_next;
            a_reg     <= '0;
            r_reg     <= '0;
            g_reg     <= '0;
            b_reg     <= '0;
        end
        if (div_ok)
        begin
            if (state_reg == S_DIVA)
            begin
                a_reg <= div_q[CH_W-1:0];
            end
            if (state_reg == S_DIVR)
            begin
                r_reg <= div_q[CH_W-1:0];
            end
            if (state_reg == S_DIVG)
            begin
                g_reg <= div_q[CH_W-1:0];
            end
            if (state_reg == S_DIVB)
            begin
                b_reg <= div_q[CH_W-1:0];
            end
        end
        if (state_reg == S_EMIT && out_free && !cfg_hit)
        begin
            out_pixel_reg <= {a_reg, r_reg, g_reg, b_reg};
            dst_x_reg     <= XY_W'(dst_col_reg);
            dst_y_reg     <= XY_W'(dst_row_reg);
            last_reg      <= (dst_col_inc == dw) && (dst_row_inc == dh);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign dst_x     = dst_x_reg;
    assign dst_y     = dst_y_reg;
    assign last      = last_reg;

`ifndef SYNTH
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_SRC_WIDTH) |=> !in_ready)
        else $error("input taken right after a register write");

    a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (div_done && div_run_reg) |-> (state_reg == S_DIVA || state_reg == S_DIVR ||
            state_reg == S_DIVG || state_reg == S_DIVB ||
            state_reg == S_BNDC || state_reg == S_BNDR))
        else $error("divider result arrived outside a divide step");

    a_read_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !cfg_we) |=> (state_reg == S_READ))
        else $error("accepted beat did not start a sum update");
`endif

endmodule
